/* design/dpf_pkg.sv */
package dpf_pkg;

   localparam int SLOTS     = 32;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(SLOTS + 1);
   localparam int KEY_BITS  = 32;
   localparam int MS_BITS   = 32;
   localparam int COPY_BITS = 8;

   localparam logic [MS_BITS-1:0]   TTL_RESET  = 32'd30000;
   localparam logic [MS_BITS-1:0]   STAMP_MAX  = 32'hFFFF_FFFF;
   localparam logic [COPY_BITS-1:0] COPY_MAX   = 8'd255;
   localparam logic [COPY_BITS-1:0] COPY_FIRST = 8'd1;

   localparam logic [1:0] CMD_SIGHT  = 2'd0;
   localparam logic [1:0] CMD_QUERY  = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]          command;
      logic [KEY_BITS-1:0] src;
      logic [KEY_BITS-1:0] id;
      logic [MS_BITS-1:0]  now_ms;
   } dpf_req_type;

   typedef struct packed {
      logic                 is_new;
      logic [COPY_BITS-1:0] copy_count;
   } dpf_rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]  source;
      logic [KEY_BITS-1:0]  ident;
      logic [MS_BITS-1:0]   stamp;
      logic [COPY_BITS-1:0] copies;
   } dpf_entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
      logic emit;
   } dpf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
   } dpf_status_type;

endpackage

/* design/dpf_ctrl.sv */
module dpf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dpf_pkg::dpf_status_type status,
   output dpf_pkg::dpf_cmd_type    cmd
);
   import dpf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/dpf_datapath.sv */
module dpf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  dpf_pkg::dpf_cmd_type          cmd,
   output dpf_pkg::dpf_status_type       status,
   input  dpf_pkg::dpf_req_type          req_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dpf_pkg::MS_BITS-1:0]   csr_data,
   output dpf_pkg::dpf_rsp_type          rsp_data
);
   import dpf_pkg::*;

   dpf_entry_type mem [SLOTS];

   logic [MS_BITS-1:0]   ttl_ff;
   dpf_req_type          req_ff;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 ev_go_ff, ev_go_in;
   logic [SLOT_BITS-1:0] ev_idx_ff;
   dpf_entry_type        rd_entry_ff;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic                 hit_ff, hit_in;
   logic [SLOT_BITS-1:0] hit_idx_ff, hit_idx_in;
   dpf_entry_type        hit_entry_ff, hit_entry_in;
   logic                 free_ff, free_in;
   logic [SLOT_BITS-1:0] free_idx_ff, free_idx_in;
   logic [MS_BITS-1:0]   oldest_at_ff, oldest_at_in;
   logic [SLOT_BITS-1:0] oldest_idx_ff, oldest_idx_in;
   dpf_rsp_type          res_ff, res_in;
   dpf_rsp_type          rsp_ff;

   logic                 issue;
   logic                 ev_valid;
   logic [MS_BITS-1:0]   age;
   logic                 expired;
   logic                 live;
   logic                 key_match;
   logic                 is_sight;
   logic [SLOT_BITS-1:0] victim;
   logic [COPY_BITS-1:0] bumped;
   logic                 mem_we;
   logic [SLOT_BITS-1:0] wr_idx;
   dpf_entry_type        wr_entry;

   assign csr_ready = 1'b1;
   assign rsp_data  = rsp_ff;

   assign issue     = cmd.scan && (cnt_ff < CNT_BITS'(SLOTS));
   assign ev_valid  = valid_ff[ev_idx_ff];
   assign age       = req_ff.now_ms - rd_entry_ff.stamp;
   assign expired   = ev_valid && (age > ttl_ff);
   assign live      = ev_valid && !expired;
   assign key_match = (rd_entry_ff.source == req_ff.src) && (rd_entry_ff.ident == req_ff.id);
   assign is_sight  = (req_ff.command == CMD_SIGHT);
   assign victim    = free_ff ? free_idx_ff : oldest_idx_ff;
   assign bumped    = (hit_entry_ff.copies == COPY_MAX) ? COPY_MAX
                                                         : hit_entry_ff.copies + COPY_FIRST;

   assign status.scan_last = ev_go_ff && (ev_idx_ff == SLOT_BITS'(SLOTS - 1));

   // scan counter and read-side stage
   always_comb begin
      cnt_in   = cnt_ff;
      ev_go_in = 1'b0;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in   = cnt_ff + 1'b1;
         ev_go_in = 1'b1;
      end
   end

   // merged pass: expiry, match, first free slot and oldest entry; commit writes back and forms the result
   always_comb begin
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      oldest_at_in  = oldest_at_ff;
      oldest_idx_in = oldest_idx_ff;
      res_in        = res_ff;
      mem_we        = 1'b0;
      wr_idx        = hit_idx_ff;
      wr_entry      = hit_entry_ff;
      if (cmd.load) begin
         hit_in        = 1'b0;
         free_in       = 1'b0;
         oldest_at_in  = STAMP_MAX;
         oldest_idx_in = '0;
      end else if (ev_go_ff) begin
         if (expired && is_sight) begin
            valid_in[ev_idx_ff] = 1'b0;
         end
         if (!live && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = ev_idx_ff;
         end
         if (live && key_match && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = ev_idx_ff;
            hit_entry_in = rd_entry_ff;
         end
         if (live && (rd_entry_ff.stamp < oldest_at_ff)) begin
            oldest_at_in  = rd_entry_ff.stamp;
            oldest_idx_in = ev_idx_ff;
         end
      end else if (cmd.commit) begin
         res_in = '0;
         unique case (req_ff.command)
            CMD_SIGHT: begin
               mem_we = 1'b1;
               if (hit_ff) begin
                  wr_idx            = hit_idx_ff;
                  wr_entry          = hit_entry_ff;
                  wr_entry.copies   = bumped;
                  res_in.copy_count = bumped;
               end else begin
                  wr_idx            = victim;
                  wr_entry.source   = req_ff.src;
                  wr_entry.ident    = req_ff.id;
                  wr_entry.stamp    = req_ff.now_ms;
                  wr_entry.copies   = COPY_FIRST;
                  valid_in[victim]  = 1'b1;
                  res_in.is_new     = 1'b1;
                  res_in.copy_count = COPY_FIRST;
               end
            end
            CMD_QUERY: begin
               if (hit_ff) begin
                  res_in.copy_count = hit_entry_ff.copies;
               end
            end
            CMD_CLEAR: begin
               valid_in = '0;
            end
            CMD_UNUSED: begin
               res_in = '0;
            end
            default: begin
               res_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_entry_ff <= mem[cnt_ff[SLOT_BITS-1:0]];
      end
      if (mem_we) begin
         mem[wr_idx] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff   <= TTL_RESET;
         valid_ff <= '0;
         cnt_ff   <= '0;
         ev_go_ff <= 1'b0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            ttl_ff <= csr_data;
         end
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         ev_go_ff <= ev_go_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (issue) begin
         ev_idx_ff <= cnt_ff[SLOT_BITS-1:0];
      end
      hit_idx_ff    <= hit_idx_in;
      hit_entry_ff  <= hit_entry_in;
      free_idx_ff   <= free_idx_in;
      oldest_at_ff  <= oldest_at_in;
      oldest_idx_ff <= oldest_idx_in;
      res_ff        <= res_in;
      if (cmd.emit) begin
         rsp_ff <= res_ff;
      end
   end

endmodule

/* design/duplicate_packet_filter.sv */
// Duplicate packet filter: remembers recently seen (src, id) keys with arrival
// time and copy count.
// req channel: one transaction per command (sighting, query, clear); it is
// taken only while no command is in progress.
// rsp channel: exactly one transaction per command, is_new and copy_count.
// csr channel: writes ttl_ms; always ready, write only while the block is idle.
// The table is walked one slot per cycle through the single read port of
// the slot memory, followed by a write-back state.
// Reset clears every slot's valid bit, sets ttl_ms to 30000 and empties the
// output register; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and processed, and waits at its end until the
// output register is free.
module duplicate_packet_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  dpf_pkg::dpf_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dpf_pkg::dpf_rsp_type        rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [dpf_pkg::MS_BITS-1:0] csr_data
);
   import dpf_pkg::*;

   dpf_cmd_type    cmd;
   dpf_status_type status;

   dpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

/* design/dpf_checker.sv */
module dpf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input dpf_pkg::dpf_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dpf_pkg::dpf_rsp_type rsp_data
);
   import dpf_pkg::*;

   // a stalled response transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a new key always starts with one copy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.is_new || (rsp_data.copy_count == COPY_FIRST))
      else $error("new key without count of one");

   // only one command in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a fresh result appears only as the controller returns to idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while a command is in progress");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output not empty after reset");

endmodule

bind duplicate_packet_filter dpf_checker u_dpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/sv/tb_duplicate_packet_filter.sv */
module tb_duplicate_packet_filter;
   import dpf_pkg::*;

   localparam int POOL_SIZE      = 40;
   localparam int SETTLE_CYCLES  = SLOTS + 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT   = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   dpf_req_type         req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   dpf_rsp_type         rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [MS_BITS-1:0]  csr_data = '0;

   // predictor copy of the key table and the ttl register
   logic                 seen_valid  [SLOTS];
   logic [KEY_BITS-1:0]  seen_src    [SLOTS];
   logic [KEY_BITS-1:0]  seen_id     [SLOTS];
   logic [MS_BITS-1:0]   seen_time   [SLOTS];
   logic [COPY_BITS-1:0] seen_copies [SLOTS];
   logic [MS_BITS-1:0]   ttl_setting = TTL_RESET;

   dpf_req_type commands_to_send [$];
   dpf_rsp_type verdicts_due [$];

   logic [KEY_BITS-1:0] pool_src [POOL_SIZE];
   logic [KEY_BITS-1:0] pool_id  [POOL_SIZE];
   logic [MS_BITS-1:0]  now_clock = '0;

   int   issued = 0;
   int   accepted = 0;
   int   fault_count = 0;
   int   idle_cycles = 0;
   logic req_accepted = 1'b0;

   int   burst_left = 1;
   int   gap_left = 0;
   int   bursts_started = 0;
   logic drain_first = 1'b0;
   int   ready_left = 0;
   int   ready_odds = 100;

   duplicate_packet_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic dpf_rsp_type filter_verdict(input dpf_req_type r);
      dpf_rsp_type        v;
      int                 hit;
      int                 free_at;
      int                 oldest;
      int                 slot;
      logic [MS_BITS-1:0] oldest_at;
      logic [MS_BITS-1:0] age;
      v = '0;
      hit = -1;
      free_at = -1;
      oldest = 0;
      oldest_at = STAMP_MAX;
      case (r.command)
         CMD_SIGHT: begin
            // retire expired entries and pick match and victim in one pass
            for (int k = 0; k < SLOTS; k++) begin
               age = r.now_ms - seen_time[k];
               if (seen_valid[k] && age > ttl_setting) seen_valid[k] = 1'b0;
               if (!seen_valid[k]) begin
                  if (free_at < 0) free_at = k;
               end else begin
                  if (hit < 0 && seen_src[k] == r.src && seen_id[k] == r.id) hit = k;
                  if (seen_time[k] < oldest_at) begin
                     oldest_at = seen_time[k];
                     oldest = k;
                  end
               end
            end
            if (hit >= 0) begin
               if (seen_copies[hit] != COPY_MAX) seen_copies[hit] = seen_copies[hit] + 8'd1;
               v.copy_count = seen_copies[hit];
            end else begin
               slot = (free_at >= 0) ? free_at : oldest;
               seen_src[slot] = r.src;
               seen_id[slot] = r.id;
               seen_time[slot] = r.now_ms;
               seen_copies[slot] = COPY_FIRST;
               seen_valid[slot] = 1'b1;
               v.is_new = 1'b1;
               v.copy_count = COPY_FIRST;
            end
         end
         CMD_QUERY: begin
            // expired entries read as absent but stay in the table
            for (int k = SLOTS - 1; k >= 0; k--) begin
               age = r.now_ms - seen_time[k];
               if (seen_valid[k] && age <= ttl_setting && seen_src[k] == r.src &&
                   seen_id[k] == r.id)
                  v.copy_count = seen_copies[k];
            end
         end
         CMD_CLEAR: begin
            for (int k = 0; k < SLOTS; k++) seen_valid[k] = 1'b0;
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic queue_cmd(input logic [1:0] c, input logic [KEY_BITS-1:0] s,
                            input logic [KEY_BITS-1:0] i, input logic [MS_BITS-1:0] t);
      dpf_req_type r;
      r.command = c;
      r.src = s;
      r.id = i;
      r.now_ms = t;
      commands_to_send.push_back(r);
   endtask

   task automatic settle();
      do @(negedge clock);
      while (commands_to_send.size() != 0 || issued != accepted || verdicts_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_ttl(input logic [MS_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int count, input logic [MS_BITS-1:0] max_step);
      int pick;
      int key;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 49) == 0) now_clock = $urandom;
         else now_clock = now_clock + $urandom_range(0, max_step);
         pick = $urandom_range(0, 99);
         key = $urandom_range(0, POOL_SIZE - 1);
         if (pick < 55) queue_cmd(CMD_SIGHT, pool_src[key], pool_id[key], now_clock);
         else if (pick < 78) queue_cmd(CMD_QUERY, pool_src[key], pool_id[key], now_clock);
         else if (pick < 82) queue_cmd(CMD_CLEAR, $urandom, $urandom, now_clock);
         else if (pick < 86) queue_cmd(CMD_UNUSED, $urandom, $urandom, $urandom);
         else if (pick < 93) queue_cmd(CMD_SIGHT, $urandom, $urandom, now_clock);
         else queue_cmd(CMD_QUERY, $urandom, $urandom, $urandom);
      end
   endtask

   // request driver: bursts of transactions separated by random gaps
   always @(negedge clock) begin
      logic send;
      send = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (drain_first) begin
            // hold until every outstanding result has come back
            if (verdicts_due.size() == 0 && issued == accepted) drain_first = 1'b0;
         end else if (commands_to_send.size() > 0) begin
            req_data <= commands_to_send.pop_front();
            issued++;
            send = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
               bursts_started++;
               drain_first = (bursts_started == 3) || ($urandom_range(0, 5) == 0);
            end
         end
         req_valid <= send;
      end
   end

   // response acceptor: stall pattern in segments of differing readiness
   always @(negedge clock) begin
      if (ready_left == 0) begin
         case ($urandom_range(0, 4))
            0, 1:    ready_odds = 100;
            2:       ready_odds = 70;
            3:       ready_odds = 30;
            default: ready_odds = 0;
         endcase
         ready_left = (ready_odds == 0) ? $urandom_range(1, 60) : $urandom_range(5, 80);
      end
      ready_left--;
      rsp_ready <= ($urandom_range(1, 100) <= ready_odds);
   end

   always @(posedge clock) begin
      dpf_rsp_type want;
      logic        moved;
      moved = 1'b0;
      req_accepted = 1'b0;
      if (reset) begin
         ttl_setting = TTL_RESET;
         for (int k = 0; k < SLOTS; k++) seen_valid[k] = 1'b0;
         idle_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            ttl_setting = csr_data;
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (verdicts_due.size() == 0) begin
               report_fault($sformatf("unexpected result is_new=%0d copy_count=%0d",
                                      rsp_data.is_new, rsp_data.copy_count));
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_data.is_new !== want.is_new || rsp_data.copy_count !== want.copy_count)
                  report_fault($sformatf("is_new exp %0d got %0d, copy_count exp %0d got %0d",
                                         want.is_new, rsp_data.is_new,
                                         want.copy_count, rsp_data.copy_count));
            end
         end
         if (req_valid && req_ready) begin
            verdicts_due.push_back(filter_verdict(req_data));
            req_accepted = 1'b1;
            accepted++;
            moved = 1'b1;
         end
         if (moved) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [MS_BITS-1:0] ttl_pick;
      pool_src[0] = '0;           pool_id[0] = '0;
      pool_src[1] = STAMP_MAX;    pool_id[1] = STAMP_MAX;
      pool_src[2] = '0;           pool_id[2] = STAMP_MAX;
      pool_src[3] = STAMP_MAX;    pool_id[3] = '0;
      // every third key shares its source with the one before
      for (int k = 4; k < POOL_SIZE; k++) begin
         pool_src[k] = (k % 3 == 0) ? pool_src[k - 1] : $urandom;
         pool_id[k] = $urandom;
      end
      now_clock = $urandom;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed checks at the reset ttl of 30000
      queue_cmd(CMD_QUERY, 32'h0A0B_0C0D, 32'h0000_0011, 32'd0);
      queue_cmd(CMD_SIGHT, 32'h0A0B_0C0D, 32'h0000_0011, 32'd1000);
      queue_cmd(CMD_SIGHT, 32'h0A0B_0C0D, 32'h0000_0011, 32'd2000);
      queue_cmd(CMD_QUERY, 32'h0A0B_0C0D, 32'h0000_0011, 32'd31000);
      queue_cmd(CMD_QUERY, 32'h0A0B_0C0D, 32'h0000_0011, 32'd31001);
      queue_cmd(CMD_QUERY, 32'h0A0B_0C0D, 32'h0000_0011, 32'd2000);
      queue_cmd(CMD_SIGHT, 32'h0A0B_0C0D, 32'h0000_0012, 32'd2000);
      queue_cmd(CMD_SIGHT, 32'h0A0B_0C0D, 32'h0000_0011, 32'd40000);
      queue_cmd(CMD_SIGHT, STAMP_MAX, '0, 32'hFFFF_FFF0);
      // age across the wrap of the millisecond counter
      queue_cmd(CMD_SIGHT, STAMP_MAX, '0, 32'h0000_0010);
      queue_cmd(CMD_SIGHT, '0, STAMP_MAX, 32'h0000_0010);
      queue_cmd(CMD_QUERY, STAMP_MAX, '0, 32'h0000_0010);
      queue_cmd(CMD_UNUSED, 32'h5A5A_A5A5, 32'hC3C3_3C3C, 32'h1234_5678);
      queue_cmd(CMD_UNUSED, STAMP_MAX, '0, 32'h0000_0010);
      queue_cmd(CMD_CLEAR, 32'h1357_9BDF, 32'h2468_ACE0, 32'h0000_0010);
      queue_cmd(CMD_QUERY, STAMP_MAX, '0, 32'h0000_0010);
      queue_cmd(CMD_SIGHT, STAMP_MAX, '0, 32'h0000_0010);
      queue_cmd(CMD_SIGHT, STAMP_MAX, STAMP_MAX, STAMP_MAX);
      queue_cmd(CMD_CLEAR, STAMP_MAX, STAMP_MAX, STAMP_MAX);
      settle();

      // full table with nothing expiring: all times equal, then descending times
      write_ttl(STAMP_MAX);
      for (int k = 0; k < SLOTS; k++)
         queue_cmd(CMD_SIGHT, 32'h1000_0000 + k, ~k, STAMP_MAX);
      queue_cmd(CMD_SIGHT, 32'h2000_0000, 32'h2000_0000, STAMP_MAX);
      queue_cmd(CMD_QUERY, 32'h1000_0000, ~0, STAMP_MAX);
      queue_cmd(CMD_QUERY, 32'h1000_0001, ~1, STAMP_MAX);
      // saturate the copy count
      for (int k = 0; k < 258; k++)
         queue_cmd(CMD_SIGHT, 32'h1000_0001, ~1, STAMP_MAX);
      queue_cmd(CMD_QUERY, 32'h1000_0001, ~1, STAMP_MAX);
      queue_cmd(CMD_CLEAR, '0, '0, '0);
      for (int k = 0; k < SLOTS; k++)
         queue_cmd(CMD_SIGHT, 32'h3000_0000 + k, k, 32'd5000 - 10 * k);
      queue_cmd(CMD_SIGHT, 32'h4000_0000, 32'h4000_0000, 32'd6000);
      queue_cmd(CMD_QUERY, 32'h3000_001F, 32'd31, 32'd6000);
      queue_cmd(CMD_QUERY, 32'h3000_001E, 32'd30, 32'd6000);
      queue_cmd(CMD_SIGHT, 32'h3000_001F, 32'd31, 32'd6000);
      settle();

      write_ttl(32'd0);
      random_phase(50, 32'd1);
      settle();
      write_ttl(32'd200);
      random_phase(50, 32'd60);
      settle();
      write_ttl(TTL_RESET);
      random_phase(50, 32'd8000);
      settle();
      write_ttl(32'd1);
      random_phase(50, 32'd2);
      settle();
      ttl_pick = $urandom;
      write_ttl(ttl_pick);
      random_phase(50, ttl_pick >> 3);
      settle();
      write_ttl(STAMP_MAX);
      random_phase(50, STAMP_MAX);
      settle();

      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* duplicate_packet_filter.f */
design/dpf_pkg.sv
design/dpf_ctrl.sv
design/dpf_datapath.sv
design/duplicate_packet_filter.sv
design/dpf_checker.sv
tb/sv/tb_duplicate_packet_filter.sv
